/* src/source_token_lexer_defines.svh */
// Assertion macros shared by the lexer modules.
`ifndef SOURCE_TOKEN_LEXER_DEFINES_SVH
`define SOURCE_TOKEN_LEXER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define STL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition in one cycle that forces another in the next cycle.
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/stl_pkg.sv */
// Types, constants and classification functions of the source token lexer.
package stl_pkg;

  localparam int POS_BITS_DEFAULT    = 16;
  localparam int KEYWORD_MAX_DEFAULT = 6;
  localparam int QUEUE_DEPTH         = 4;

  localparam int KIND_W  = 6;
  localparam int START_W = 16;
  localparam int LEN_W   = 16;
  localparam int PREC_W  = 3;

  localparam int KW_COUNT   = 12;
  localparam int KW_MAX_LEN = 6;
  localparam int KW_W       = 8 * KW_MAX_LEN;

  typedef enum logic [KIND_W-1:0] {
    TK_LET        = 6'd0,
    TK_CONST      = 6'd1,
    TK_RETURN     = 6'd2,
    TK_FN         = 6'd3,
    TK_TRUE       = 6'd4,
    TK_FALSE      = 6'd5,
    TK_NIL        = 6'd6,
    TK_FOR        = 6'd7,
    TK_RANGE      = 6'd8,
    TK_IN         = 6'd9,
    TK_IF         = 6'd10,
    TK_ELSE       = 6'd11,
    TK_IDENT      = 6'd12,
    TK_INT        = 6'd13,
    TK_STRING     = 6'd14,
    TK_DOT        = 6'd15,
    TK_DOUBLE_DOT = 6'd16,
    TK_LPAREN     = 6'd17,
    TK_RPAREN     = 6'd18,
    TK_LBRACKET   = 6'd19,
    TK_RBRACKET   = 6'd20,
    TK_LCURLY     = 6'd21,
    TK_RCURLY     = 6'd22,
    TK_PLUS       = 6'd23,
    TK_MINUS      = 6'd24,
    TK_ASTERISK   = 6'd25,
    TK_SLASH      = 6'd26,
    TK_PERCENT    = 6'd27,
    TK_SEMICOLON  = 6'd28,
    TK_COMMA      = 6'd29,
    TK_ASSIGN     = 6'd30,
    TK_EQUAL      = 6'd31,
    TK_BANG       = 6'd32,
    TK_NOT_EQUAL  = 6'd33,
    TK_GT         = 6'd34,
    TK_GTE        = 6'd35,
    TK_LT         = 6'd36,
    TK_LTE        = 6'd37,
    TK_ILLEGAL    = 6'd38,
    TK_EOF        = 6'd39
  } tkind_t;

  typedef enum logic [3:0] {
    PC_NONE   = 4'd0,
    PC_INT    = 4'd1,
    PC_IDENT  = 4'd2,
    PC_STRING = 4'd3,
    PC_EQ     = 4'd4,
    PC_BANG   = 4'd5,
    PC_GT     = 4'd6,
    PC_LT     = 4'd7,
    PC_DOT    = 4'd8
  } pclass_t;

  typedef struct packed {
    tkind_t             kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } tok_t;

  // One queue entry holds every token that one input transfer produced.
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } entry_t;

  typedef struct packed {
    logic    emit;
    tkind_t  kind;
    logic    start;
    pclass_t pc;
  } fresh_t;

  // Keyword text is right-justified: the last character sits in the low byte.
  localparam logic [KW_W-1:0] KW_TEXT [KW_COUNT] = '{
    KW_W'("let"),   KW_W'("const"), KW_W'("return"), KW_W'("fn"),
    KW_W'("true"),  KW_W'("false"), KW_W'("nil"),    KW_W'("for"),
    KW_W'("range"), KW_W'("in"),    KW_W'("if"),     KW_W'("else")
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd5, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd3, 3'd5, 3'd2, 3'd2, 3'd4
  };

  function automatic logic is_num(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // Decode of a byte that arrives with nothing pending.
  function automatic fresh_t fresh_of(logic [7:0] c);
    fresh_t f;
    f = '{emit: 1'b0, kind: TK_ILLEGAL, start: 1'b0, pc: PC_NONE};
    unique case (c)
      "%": begin f.emit = 1'b1; f.kind = TK_PERCENT;   end
      ";": begin f.emit = 1'b1; f.kind = TK_SEMICOLON; end
      "+": begin f.emit = 1'b1; f.kind = TK_PLUS;      end
      "-": begin f.emit = 1'b1; f.kind = TK_MINUS;     end
      "*": begin f.emit = 1'b1; f.kind = TK_ASTERISK;  end
      "/": begin f.emit = 1'b1; f.kind = TK_SLASH;     end
      "(": begin f.emit = 1'b1; f.kind = TK_LPAREN;    end
      ")": begin f.emit = 1'b1; f.kind = TK_RPAREN;    end
      "{": begin f.emit = 1'b1; f.kind = TK_LCURLY;    end
      "}": begin f.emit = 1'b1; f.kind = TK_RCURLY;    end
      "[": begin f.emit = 1'b1; f.kind = TK_LBRACKET;  end
      "]": begin f.emit = 1'b1; f.kind = TK_RBRACKET;  end
      ",": begin f.emit = 1'b1; f.kind = TK_COMMA;     end
      "=": begin f.start = 1'b1; f.pc = PC_EQ;     end
      "!": begin f.start = 1'b1; f.pc = PC_BANG;   end
      ">": begin f.start = 1'b1; f.pc = PC_GT;     end
      "<": begin f.start = 1'b1; f.pc = PC_LT;     end
      ".": begin f.start = 1'b1; f.pc = PC_DOT;    end
      "\"": begin f.start = 1'b1; f.pc = PC_STRING; end
      default: begin
        if (is_num(c)) begin
          f.start = 1'b1;
          f.pc    = PC_INT;
        end else if (is_word(c)) begin
          f.start = 1'b1;
          f.pc    = PC_IDENT;
        end else if (!is_blank(c)) begin
          f.emit = 1'b1;
          f.kind = TK_ILLEGAL;
        end
      end
    endcase
    return f;
  endfunction

  // Second character that turns a pending one-character operator into a pair.
  function automatic logic [7:0] second_of(pclass_t pc);
    return (pc == PC_DOT) ? 8'(".") : 8'("=");
  endfunction

  function automatic tkind_t single_of(pclass_t pc);
    tkind_t k;
    unique case (pc)
      PC_EQ:   k = TK_ASSIGN;
      PC_BANG: k = TK_BANG;
      PC_GT:   k = TK_GT;
      PC_LT:   k = TK_LT;
      default: k = TK_DOT;
    endcase
    return k;
  endfunction

  function automatic tkind_t double_of(pclass_t pc);
    tkind_t k;
    unique case (pc)
      PC_EQ:   k = TK_EQUAL;
      PC_BANG: k = TK_NOT_EQUAL;
      PC_GT:   k = TK_GTE;
      PC_LT:   k = TK_LTE;
      default: k = TK_DOUBLE_DOT;
    endcase
    return k;
  endfunction

  // Twelve parallel compares of the low bytes of the word buffer.
  // Words longer than any keyword never match on length.
  function automatic tkind_t kw_kind(logic [KW_W-1:0] prefix, logic [LEN_W-1:0] len);
    tkind_t          k;
    logic [KW_W-1:0] mask;
    k = TK_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      mask = ~({KW_W{1'b1}} << (8 * int'(KW_LEN[i])));
      if ((len == LEN_W'(KW_LEN[i])) && ((prefix & mask) == KW_TEXT[i])) begin
        k = tkind_t'(KIND_W'(i));
      end
    end
    return k;
  endfunction

  function automatic logic [PREC_W-1:0] prec_of(tkind_t k);
    logic [PREC_W-1:0] p;
    unique case (k)
      TK_PLUS, TK_MINUS:     p = 3'd1;
      TK_ASTERISK, TK_SLASH: p = 3'd2;
      TK_PERCENT:            p = 3'd3;
      TK_EQUAL, TK_NOT_EQUAL, TK_GT, TK_GTE, TK_LT, TK_LTE: p = 3'd4;
      default:               p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

/* src/stl_ifs.sv */
// Valid/ready channel interfaces for source bytes and tokens.
interface stl_byte_if import stl_pkg::*;;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] ch;

  modport source (output valid, output kind, output ch, input ready);
  modport sink   (input valid, input kind, input ch, output ready);
endinterface

interface stl_token_if import stl_pkg::*;;
  logic               valid;
  logic               ready;
  tkind_t             token_kind;
  logic [START_W-1:0] start_pos;
  logic [LEN_W-1:0]   text_len;
  logic [PREC_W-1:0]  precedence;
  logic               is_operator;
  logic               last;

  modport source (output valid, output token_kind, output start_pos, output text_len,
                  output precedence, output is_operator, output last, input ready);
  modport sink   (input valid, input token_kind, input start_pos, input text_len,
                  input precedence, input is_operator, input last, output ready);
endinterface

/* src/stl_front.sv */
// Front end: accepts source bytes, tracks the pending token and builds queue entries.
module stl_front import stl_pkg::*; #(
  parameter int POS_BITS    = POS_BITS_DEFAULT,
  parameter int KEYWORD_MAX = KEYWORD_MAX_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  stl_byte_if.sink     text,
  input  logic         full,
  output logic         push,
  output entry_t       entry
);

  `include "source_token_lexer_defines.svh"

  localparam int PRE_W = 8 * KEYWORD_MAX;

  logic [POS_BITS-1:0] pos, pos_next;
  pclass_t             pclass, pclass_next;
  logic [POS_BITS-1:0] tstart, tstart_next;
  logic [PRE_W-1:0]    prefix, prefix_next;
  logic [LEN_W-1:0]    wlen, wlen_next;

  logic       accept;
  logic       is_end;
  logic [7:0] c;
  fresh_t     fr;
  logic       use_fresh;
  logic       t0v, t1v;
  tok_t       t0, t1;
  tok_t       fl_tok;
  logic [LEN_W-1:0] wlen_inc;

  assign text.ready = !full;
  assign accept     = text.valid && text.ready;
  assign c          = text.ch;
  assign is_end     = text.kind || (c == 8'd0);
  assign fr         = fresh_of(c);
  assign wlen_inc   = (wlen == {LEN_W{1'b1}}) ? wlen : wlen + 1'b1;

  // Token that the pending class gives when it is closed off.
  always_comb begin
    fl_tok.start = START_W'(tstart);
    fl_tok.len   = '0;
    unique case (pclass)
      PC_INT:    begin fl_tok.kind = TK_INT;    fl_tok.len = wlen; end
      PC_IDENT:  begin
        fl_tok.kind = kw_kind(prefix[KW_W-1:0], wlen);
        fl_tok.len  = wlen;
      end
      PC_STRING: begin fl_tok.kind = TK_STRING; fl_tok.len = wlen; end
      default:   fl_tok.kind = single_of(pclass);
    endcase
  end

  always_comb begin
    pos_next    = pos + 1'b1;
    pclass_next = pclass;
    tstart_next = tstart;
    prefix_next = prefix;
    wlen_next   = wlen;
    use_fresh   = 1'b0;
    t0v = 1'b0;
    t1v = 1'b0;
    t0  = fl_tok;
    t1  = '{kind: fr.kind, start: START_W'(pos), len: '0};

    if (is_end) begin
      t0v         = (pclass != PC_NONE);
      t1v         = 1'b1;
      t1.kind     = TK_EOF;
      pos_next    = '0;
      pclass_next = PC_NONE;
      tstart_next = '0;
      wlen_next   = '0;
    end else begin
      unique case (pclass)
        PC_INT: begin
          if (is_num(c)) begin
            wlen_next = wlen_inc;
          end else begin
            t0v = 1'b1;
            pclass_next = PC_NONE;
            use_fresh = 1'b1;
          end
        end
        PC_IDENT: begin
          if (is_word(c)) begin
            prefix_next = {prefix[PRE_W-9:0], c};
            wlen_next   = wlen_inc;
          end else begin
            t0v = 1'b1;
            pclass_next = PC_NONE;
            use_fresh = 1'b1;
          end
        end
        PC_STRING: begin
          if (c == "\"") begin
            t0v = 1'b1;
            pclass_next = PC_NONE;
          end else begin
            wlen_next = wlen_inc;
          end
        end
        PC_EQ, PC_BANG, PC_GT, PC_LT, PC_DOT: begin
          t0v = 1'b1;
          pclass_next = PC_NONE;
          if (c == second_of(pclass)) begin
            t0.kind = double_of(pclass);
          end else begin
            use_fresh = 1'b1;
          end
        end
        default: begin
          pclass_next = PC_NONE;
          use_fresh = 1'b1;
        end
      endcase

      if (use_fresh) begin
        t1v = fr.emit;
        if (fr.start) begin
          pclass_next = fr.pc;
          tstart_next = (fr.pc == PC_STRING) ? pos + 1'b1 : pos;
          wlen_next   = ((fr.pc == PC_INT) || (fr.pc == PC_IDENT)) ? LEN_W'(1) : '0;
          if (fr.pc == PC_IDENT) begin
            prefix_next = {prefix[PRE_W-9:0], c};
          end
        end
      end
    end
  end

  assign push       = accept && (t0v || t1v);
  assign entry.two  = t0v && t1v;
  assign entry.tok0 = t0v ? t0 : t1;
  assign entry.tok1 = t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      pclass <= PC_NONE;
      tstart <= '0;
      wlen   <= '0;
    end else if (accept) begin
      pos    <= pos_next;
      pclass <= pclass_next;
      tstart <= tstart_next;
      wlen   <= wlen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prefix <= prefix_next;
    end
  end

  `STL_ASSERT_NEXT(a_end_clears, accept && is_end, (pos == '0) && (pclass == PC_NONE), "end transfer did not clear lexer state")
  `STL_ASSERT_ALWAYS(a_end_pushes, !(accept && is_end) || push, "end transfer produced no queue entry")

endmodule

/* src/stl_queue.sv */
// Short entry queue between the front and back ends.
module stl_queue import stl_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t din,
  output logic   full,
  input  logic   pop,
  output logic   nonempty,
  output entry_t head
);

  `include "source_token_lexer_defines.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  `STL_ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into a full queue")
  `STL_ASSERT_ALWAYS(a_no_underflow, !(pop && !nonempty), "pop from an empty queue")

endmodule

/* src/stl_back.sv */
// Back end: splits queue entries into single tokens and drives the output register.
module stl_back import stl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        nonempty,
  input  entry_t      head,
  output logic        pop,
  stl_token_if.source tokens
);

  `include "source_token_lexer_defines.svh"

  logic sel;
  logic load;
  logic is_last;
  tok_t tok;

  assign load    = !tokens.valid || tokens.ready;
  assign tok     = sel ? head.tok1 : head.tok0;
  assign is_last = sel || !head.two;
  assign pop     = load && nonempty && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel          <= 1'b0;
      tokens.valid <= 1'b0;
    end else if (load) begin
      tokens.valid <= nonempty;
      if (nonempty) begin
        sel <= !is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && nonempty) begin
      tokens.token_kind  <= tok.kind;
      tokens.start_pos   <= tok.start;
      tokens.text_len    <= tok.len;
      tokens.precedence  <= prec_of(tok.kind);
      tokens.is_operator <= (prec_of(tok.kind) != '0) && (tok.kind != TK_PERCENT);
      tokens.last        <= is_last;
    end
  end

  `STL_ASSERT_ALWAYS(a_sel_two, !sel || (nonempty && head.two), "second token selected without a two-token entry")
  `STL_ASSERT_NEXT(a_pop_ends_entry, pop, sel == 1'b0, "entry popped but second token still selected")

endmodule

/* src/source_token_lexer.sv */
// Top level of the byte-serial source token lexer.
//
//   channel  role   payload                                              transfer when
//   text     sink   kind, ch                                             valid && ready
//   tokens   source token_kind, start_pos, text_len, precedence,         valid && ready
//                   is_operator, last
//
// A byte is taken in every cycle while the entry queue has room; the front end
// settles each byte in the cycle of its transfer, so its tokens pass only through
// the queue and the output register before they appear on the token side.
// The output register issues one token a cycle while tokens.ready is high, so a byte
// that closes two tokens ("x+", or an end with a token pending) sends both in turn.
// Reset is synchronous and clears position, pending token, queue and output valid.
// A stalled token side fills the four-entry queue and then drops text.ready; the
// front end keeps accepting while a finished token waits to be taken.
module source_token_lexer import stl_pkg::*; #(
  parameter int POS_BITS    = POS_BITS_DEFAULT,
  parameter int KEYWORD_MAX = KEYWORD_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  stl_byte_if.sink    text,
  stl_token_if.source tokens
);

  // Entries carry all tokens that one byte produced, so "last" is known
  // per entry and the back end never has to look ahead across entries.
  logic   push;
  logic   full;
  logic   pop;
  logic   nonempty;
  entry_t entry;
  entry_t head;

  stl_front #(
    .POS_BITS    (POS_BITS),
    .KEYWORD_MAX (KEYWORD_MAX)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .full  (full),
    .push  (push),
    .entry (entry)
  );

  stl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (entry),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  stl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .tokens   (tokens)
  );

endmodule

/* tb/tb_source_token_lexer.sv */
// Self-checking testbench for the byte-serial source token lexer.
module tb_source_token_lexer import stl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default sizes, so positions are 16 bits wide
  // and the word buffer holds six characters, so no longer word is a keyword.
  localparam int POS_W    = POS_BITS_DEFAULT;
  localparam int KW_LIMIT = KEYWORD_MAX_DEFAULT;

  // Number of source bytes, directed ones included, after which the random part stops.
  localparam int STIM_TARGET = 550;

  // Idling regime of the two channels while a byte is in flight.
  typedef enum logic [1:0] {
    PH_SLOW_SINK,    // sender idles now and then, the token side mostly stalls
    PH_SLOW_SOURCE,  // the other way round
    PH_NO_IDLE       // both sides run flat out
  } phase_t;

  typedef struct {
    logic       is_end;
    logic [7:0] ch;
    phase_t     phase;
  } src_byte_t;

  typedef struct {
    tkind_t             kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic [PREC_W-1:0]  prec;
    logic               is_op;
    logic               last;
  } token_rec_t;

  logic clk = 1'b0;
  logic rst;

  stl_byte_if  src_text ();
  stl_token_if tok_out ();

  source_token_lexer u_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (src_text),
    .tokens (tok_out)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Source bytes still to be sent and tokens predicted but not yet seen.
  src_byte_t  pending_bytes [$];
  token_rec_t expected_tokens [$];

  int     fail_count = 0;
  int     stim_count = 0;
  phase_t gen_phase  = PH_SLOW_SINK;
  logic   byte_taken = 1'b0;
  int     tx_idle    = 0;
  int     rx_idle    = 0;
  src_byte_t next_byte;

  // The twelve keywords and the token kinds that they map to.
  string  keyword_text  [12] = '{"let", "const", "return", "fn", "true", "false",
                                 "nil", "for", "range", "in", "if", "else"};
  tkind_t keyword_kinds [12] = '{TK_LET, TK_CONST, TK_RETURN, TK_FN, TK_TRUE, TK_FALSE,
                                 TK_NIL, TK_FOR, TK_RANGE, TK_IN, TK_IF, TK_ELSE};
  string  operator_text [23] = '{"+", "-", "*", "/", "%", "(", ")", "[", "]", "{", "}",
                                 ";", ",", "=", "==", "!", "!=", ">", ">=", "<", "<=",
                                 ".", ".."};
  // Bytes right at the borders of the character classes, plus the top of the range.
  logic [7:0] edge_bytes [10] = '{8'h01, 8'h08, 8'h0E, 8'h1F, 8'h3A, 8'h40, 8'h60,
                                  8'h7F, 8'h80, 8'hFF};

  // ---------------------------------------------------------------------------
  // Token predictor. Its state mirrors what the lexer keeps between bytes:
  // the running byte position, the class of the token still open, where that
  // token started, how long it is so far and the first few word characters.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] cur_pos;
  pclass_t          open_class;
  logic [POS_W-1:0] tok_begin;
  logic [7:0]       word_chars [KW_LIMIT];
  logic [LEN_W-1:0] run_len;

  function automatic logic is_numeral(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [PREC_W-1:0] prec_for(tkind_t k);
    case (k)
      TK_PLUS, TK_MINUS:     return 3'd1;
      TK_ASTERISK, TK_SLASH: return 3'd2;
      TK_PERCENT:            return 3'd3;
      TK_EQUAL, TK_NOT_EQUAL, TK_GT, TK_GTE, TK_LT, TK_LTE: return 3'd4;
      default:               return 3'd0;
    endcase
  endfunction

  task automatic reset_lexer();
    cur_pos    = '0;
    open_class = PC_NONE;
    tok_begin  = '0;
    run_len    = '0;
    for (int i = 0; i < KW_LIMIT; i++) word_chars[i] = 8'h00;
  endtask

  task automatic add_token(tkind_t k, logic [POS_W-1:0] s, logic [LEN_W-1:0] l);
    token_rec_t t;
    t.kind  = k;
    t.start = START_W'(s);
    t.len   = l;
    t.prec  = prec_for(k);
    // Percent has a precedence but is not counted as an operator.
    t.is_op = (t.prec != 3'd0) && (k != TK_PERCENT);
    t.last  = 1'b0;
    expected_tokens.push_back(t);
  endtask

  task automatic open_token(pclass_t pc, logic [POS_W-1:0] s, logic [LEN_W-1:0] l);
    open_class = pc;
    tok_begin  = s;
    run_len    = l;
  endtask

  // A word is a keyword only if its length and every character match; words
  // longer than the prefix buffer can never be keywords.
  function automatic tkind_t word_kind();
    tkind_t k;
    logic   same;
    k = TK_IDENT;
    if (run_len <= LEN_W'(KW_LIMIT)) begin
      for (int i = 0; i < 12; i++) begin
        if (LEN_W'(keyword_text[i].len()) == run_len) begin
          same = 1'b1;
          for (int j = 0; j < keyword_text[i].len(); j++) begin
            if (word_chars[j] != keyword_text[i][j]) same = 1'b0;
          end
          if (same) k = keyword_kinds[i];
        end
      end
    end
    return k;
  endfunction

  // Closes whatever token is open. One-character operators that were waiting
  // for a second character come out as their single form.
  task automatic flush_pending();
    case (open_class)
      PC_INT:    add_token(TK_INT, tok_begin, run_len);
      PC_IDENT:  add_token(word_kind(), tok_begin, run_len);
      PC_STRING: add_token(TK_STRING, tok_begin, run_len);
      PC_EQ:     add_token(TK_ASSIGN, tok_begin, '0);
      PC_BANG:   add_token(TK_BANG, tok_begin, '0);
      PC_GT:     add_token(TK_GT, tok_begin, '0);
      PC_LT:     add_token(TK_LT, tok_begin, '0);
      PC_DOT:    add_token(TK_DOT, tok_begin, '0);
      default:   ;
    endcase
    open_class = PC_NONE;
  endtask

  // A byte that arrives with no token open.
  task automatic start_token(logic [7:0] c);
    case (c)
      "%":  add_token(TK_PERCENT, cur_pos, '0);
      ";":  add_token(TK_SEMICOLON, cur_pos, '0);
      "+":  add_token(TK_PLUS, cur_pos, '0);
      "-":  add_token(TK_MINUS, cur_pos, '0);
      "*":  add_token(TK_ASTERISK, cur_pos, '0);
      "/":  add_token(TK_SLASH, cur_pos, '0);
      "(":  add_token(TK_LPAREN, cur_pos, '0);
      ")":  add_token(TK_RPAREN, cur_pos, '0);
      "{":  add_token(TK_LCURLY, cur_pos, '0);
      "}":  add_token(TK_RCURLY, cur_pos, '0);
      "[":  add_token(TK_LBRACKET, cur_pos, '0);
      "]":  add_token(TK_RBRACKET, cur_pos, '0);
      ",":  add_token(TK_COMMA, cur_pos, '0);
      "=":  open_token(PC_EQ, cur_pos, '0);
      "!":  open_token(PC_BANG, cur_pos, '0);
      ">":  open_token(PC_GT, cur_pos, '0);
      "<":  open_token(PC_LT, cur_pos, '0);
      ".":  open_token(PC_DOT, cur_pos, '0);
      // The string text starts after the opening quote.
      "\"": open_token(PC_STRING, cur_pos + 1'b1, '0);
      default: begin
        if (is_numeral(c)) begin
          open_token(PC_INT, cur_pos, 16'd1);
        end else if (is_letter(c)) begin
          open_token(PC_IDENT, cur_pos, 16'd1);
          word_chars[0] = c;
        end else if (!is_space(c)) begin
          add_token(TK_ILLEGAL, cur_pos, '0);
        end
      end
    endcase
  endtask

  // Works out every token that one accepted byte produces and marks the final
  // one of them as last.
  task automatic lex_byte(logic is_end, logic [7:0] c);
    int         before_cnt;
    logic       absorbed;
    token_rec_t t;
    before_cnt = expected_tokens.size();
    absorbed   = 1'b0;
    if (is_end || (c == 8'h00)) begin
      // End of input, or a zero byte: flush, then EOF at the current position,
      // then everything starts over from position zero.
      flush_pending();
      add_token(TK_EOF, cur_pos, '0);
      reset_lexer();
    end else begin
      case (open_class)
        PC_INT: begin
          if (is_numeral(c)) begin
            if (run_len != '1) run_len = run_len + 1'b1;
            absorbed = 1'b1;
          end else begin
            flush_pending();
          end
        end
        PC_IDENT: begin
          if (is_letter(c)) begin
            if (run_len < LEN_W'(KW_LIMIT)) word_chars[run_len] = c;
            if (run_len != '1) run_len = run_len + 1'b1;
            absorbed = 1'b1;
          end else begin
            flush_pending();
          end
        end
        PC_STRING: begin
          // Every byte other than the closing quote is string text.
          if (c == "\"") flush_pending();
          else if (run_len != '1) run_len = run_len + 1'b1;
          absorbed = 1'b1;
        end
        PC_EQ, PC_BANG, PC_GT, PC_LT, PC_DOT: begin
          if (c == ((open_class == PC_DOT) ? 8'h2E : 8'h3D)) begin
            case (open_class)
              PC_EQ:   add_token(TK_EQUAL, tok_begin, '0);
              PC_BANG: add_token(TK_NOT_EQUAL, tok_begin, '0);
              PC_GT:   add_token(TK_GTE, tok_begin, '0);
              PC_LT:   add_token(TK_LTE, tok_begin, '0);
              default: add_token(TK_DOUBLE_DOT, tok_begin, '0);
            endcase
            open_class = PC_NONE;
            absorbed   = 1'b1;
          end else begin
            flush_pending();
          end
        end
        default: ;
      endcase
      if (!absorbed) start_token(c);
      cur_pos = cur_pos + 1'b1;
    end
    if (expected_tokens.size() > before_cnt) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking of the token stream.
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_token();
    token_rec_t want;
    if (expected_tokens.size() == 0) begin
      $error("token with nothing expected: token_kind %0d, start_pos %0d",
             tok_out.token_kind, tok_out.start_pos);
      fail_count++;
    end else begin
      want = expected_tokens.pop_front();
      compare_field("token_kind", 16'(want.kind), 16'(tok_out.token_kind));
      compare_field("start_pos", want.start, tok_out.start_pos);
      compare_field("text_len", want.len, tok_out.text_len);
      compare_field("precedence", 16'(want.prec), 16'(tok_out.precedence));
      compare_field("is_operator", 16'(want.is_op), 16'(tok_out.is_operator));
      compare_field("last", 16'(want.last), 16'(tok_out.last));
    end
  endtask

  // Everything is sampled at the rising edge. The prediction for a byte that
  // transfers now is queued before the token check, although a token can never
  // appear in the same cycle as the byte that caused it.
  always @(posedge clk) begin
    if (rst) begin
      reset_lexer();
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= src_text.valid && src_text.ready;
      if (src_text.valid && src_text.ready) lex_byte(src_text.kind, src_text.ch);
      if (tok_out.valid && tok_out.ready) check_token();
    end
  end

  // ---------------------------------------------------------------------------
  // Driver. Inputs change on the falling edge. A new byte is presented only
  // when the channel is empty or the previous byte transferred at the last
  // rising edge; the idling regime follows the byte at the head of the queue.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      src_text.valid <= 1'b0;
    end else if (!src_text.valid || byte_taken) begin
      if (pending_bytes.size() != 0) begin
        case (pending_bytes[0].phase)
          PH_SLOW_SINK: begin
            tx_idle = 19;
            rx_idle = 86;
          end
          PH_SLOW_SOURCE: begin
            tx_idle = 86;
            rx_idle = 19;
          end
          default: begin
            tx_idle = 0;
            rx_idle = 0;
          end
        endcase
        if ($urandom_range(99) >= tx_idle) begin
          next_byte = pending_bytes.pop_front();
          src_text.valid <= 1'b1;
          src_text.kind  <= next_byte.is_end;
          src_text.ch    <= next_byte.ch;
        end else begin
          src_text.valid <= 1'b0;
        end
      end else begin
        src_text.valid <= 1'b0;
      end
    end
    tok_out.ready <= !rst && ($urandom_range(99) >= rx_idle);
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------------
  task automatic push_byte(logic is_end, logic [7:0] c);
    src_byte_t b;
    b.is_end = is_end;
    b.ch     = c;
    b.phase  = gen_phase;
    pending_bytes.push_back(b);
    stim_count++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(1'b0, s[i]);
  endtask

  function automatic logic [7:0] random_letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] random_space();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? 8'h20 : 8'(9 + r);
  endfunction

  // One random piece of source text. Most pieces are well-formed tokens with
  // random content; tokens are often glued together without whitespace so
  // that a single byte closes one token and produces another.
  task automatic push_random_piece();
    int    r;
    int    n;
    string kw;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 15) begin
      push_text(keyword_text[$urandom_range(11)]);
    end else if (r < 30) begin
      if ($urandom_range(2) == 0) begin
        // A near miss of a keyword: one character short or one too many.
        kw = keyword_text[$urandom_range(11)];
        if ($urandom_range(1) == 0) begin
          push_text(kw.substr(0, kw.len() - 2));
        end else begin
          push_text(kw);
          push_byte(1'b0, random_letter());
        end
      end else begin
        n = ($urandom_range(4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) push_byte(1'b0, random_letter());
      end
    end else if (r < 43) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) push_byte(1'b0, 8'("0" + $urandom_range(9)));
    end else if (r < 53) begin
      push_byte(1'b0, "\"");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(1, 255));
        if (c == "\"") c = "'";
        push_byte(1'b0, c);
      end
      // Now and then the string is left open and swallows what follows.
      if ($urandom_range(9) != 0) push_byte(1'b0, "\"");
    end else if (r < 73) begin
      push_text(operator_text[$urandom_range(22)]);
    end else if (r < 85) begin
      push_byte(1'b0, random_space());
    end else if (r < 93) begin
      if ($urandom_range(1) == 0) push_byte(1'b0, edge_bytes[$urandom_range(9)]);
      else push_byte(1'b0, 8'($urandom_range(1, 255)));
    end else if (r < 97) begin
      push_byte(1'b1, 8'($urandom_range(255)));
    end else begin
      push_byte(1'b0, 8'h00);
    end
    if ((r < 73) && ($urandom_range(1) == 0)) push_byte(1'b0, random_space());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    src_text.valid = 1'b0;
    src_text.kind  = 1'b0;
    src_text.ch    = 8'h00;
    tok_out.ready  = 1'b0;

    // Directed text: single and paired operators, an operator glued to a word,
    // a dot pair, a comparison pair, an unterminated string closed by the end
    // item, the top byte, the byte just below the whitespace range, the two
    // ends of that range, and a pending assignment flushed by a zero byte.
    gen_phase = PH_SLOW_SINK;
    push_text("x+1!=y..z<=2>3\"ab");
    push_byte(1'b1, 8'h00);
    push_byte(1'b0, 8'hFF);
    push_byte(1'b0, 8'h08);
    push_byte(1'b0, 8'h09);
    push_byte(1'b0, 8'h0D);
    push_byte(1'b0, "=");
    push_byte(1'b0, 8'h00);

    // Random text, split over the three idling regimes.
    while (stim_count < STIM_TARGET) begin
      if (stim_count >= 370) gen_phase = PH_NO_IDLE;
      else if (stim_count >= 185) gen_phase = PH_SLOW_SOURCE;
      push_random_piece();
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last byte to transfer, then for the last token, then keep
    // watching the output path for anything extra.
    while ((pending_bytes.size() != 0) || src_text.valid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: the slowest correct run takes well under a fifth of this.
  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
